@@ hdl/hci_uart_packet_deframer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// hci uart packet deframer - assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef HCI_UART_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define HCI_UART_PACKET_DEFRAMER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define HUDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define HUDF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HUDF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HUDF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ hdl/hudf_pkg.sv @@
// ----------------------------------------------------------------------------
// hudf_pkg
// Types and constants shared by the hci uart packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hudf_pkg;

    // packet type bytes on the wire
    localparam logic [7:0] TYPE_CMD = 8'h01;
    localparam logic [7:0] TYPE_ACL = 8'h02;
    localparam logic [7:0] TYPE_SCO = 8'h03;

    // packet kind codes on the output
    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_ACL = 2'd1;
    localparam logic [1:0] KIND_SCO = 2'd2;

    // last header index: acl has a 4-byte header, the others 3
    localparam logic [2:0] HDR_LAST_ACL   = 3'd3;
    localparam logic [2:0] HDR_LAST_OTHER = 3'd2;
    localparam logic [2:0] HDR_LEN_INDEX  = 3'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] pkt_kind;
        logic [7:0] out_byte;
        logic       first_byte;
        logic       last_byte;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

@@ hdl/hudf_front.sv @@
// ----------------------------------------------------------------------------
// hudf_front
// Byte parser: tracks type, header and payload phases and tags each byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hci_uart_packet_deframer_unit_macros.svh"

module hudf_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire  [7:0]             i_in_byte,
    input  hudf_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output hudf_pkg::t_entry       o_entry
);
    import hudf_pkg::*;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_kind, n_kind;
    logic [2:0]  r_hdr_idx, n_hdr_idx;
    logic [7:0]  r_len_low, n_len_low;
    logic [15:0] r_left, n_left;

    logic        in_fire;
    logic        hdr_last;
    logic [15:0] hdr_len;

    assign o_ready = !i_q_status.full;
    assign in_fire = i_valid && o_ready;

    always_comb begin
        hdr_last = (r_hdr_idx >= ((r_kind == KIND_ACL) ? HDR_LAST_ACL : HDR_LAST_OTHER));
        hdr_len  = (r_kind == KIND_ACL) ? {i_in_byte, r_len_low} : {8'h00, i_in_byte};
    end

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_hdr_idx = r_hdr_idx;
        n_len_low = r_len_low;
        n_left    = r_left;
        o_push    = 1'b0;
        o_entry.pkt_kind   = r_kind;
        o_entry.out_byte   = i_in_byte;
        o_entry.first_byte = 1'b0;
        o_entry.last_byte  = 1'b0;
        if (in_fire) begin
            unique case (r_phase)
                PH_HEADER: begin
                    o_push = 1'b1;
                    o_entry.first_byte = (r_hdr_idx == 3'd0);
                    if (r_hdr_idx == HDR_LEN_INDEX) begin
                        n_len_low = i_in_byte;
                    end
                    if (hdr_last) begin
                        n_hdr_idx = 3'd0;
                        if (hdr_len == 16'd0) begin
                            o_entry.last_byte = 1'b1;
                            n_phase = PH_TYPE;
                        end else begin
                            n_left  = hdr_len;
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_hdr_idx = r_hdr_idx + 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    o_push = 1'b1;
                    if (r_left <= 16'd1) begin
                        n_left  = 16'd0;
                        o_entry.last_byte = 1'b1;
                        n_phase = PH_TYPE;
                    end else begin
                        n_left = r_left - 16'd1;
                    end
                end
                default: begin
                    n_phase = PH_TYPE;
                    // unknown type bytes are dropped to resync
                    case (i_in_byte)
                        TYPE_CMD, TYPE_ACL, TYPE_SCO: begin
                            n_kind    = i_in_byte[1:0] - 2'd1;
                            n_hdr_idx = 3'd0;
                            n_len_low = 8'h00;
                            n_left    = 16'd0;
                            n_phase   = PH_HEADER;
                        end
                        default: begin
                            n_phase = PH_TYPE;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TYPE;
            r_kind    <= KIND_CMD;
            r_hdr_idx <= 3'd0;
            r_len_low <= 8'h00;
            r_left    <= 16'd0;
        end else begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_hdr_idx <= n_hdr_idx;
            r_len_low <= n_len_low;
            r_left    <= n_left;
        end
    end

    `HUDF_ASSERT_NEVER(a_hdr_idx_range, i_clk, i_rst_n, r_hdr_idx > HDR_LAST_ACL, "header index out of range")
    `HUDF_ASSERT_NEVER(a_payload_nonzero, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) && (r_left == 16'd0), "payload phase with zero bytes left")
    `HUDF_ASSERT(a_first_in_header, i_clk, i_rst_n, (o_push && o_entry.first_byte) |-> (r_phase == PH_HEADER), "first mark outside header")
    `HUDF_ASSERT(a_last_to_type, i_clk, i_rst_n, (o_push && o_entry.last_byte) |=> (r_phase == PH_TYPE), "last byte did not end packet")

endmodule

`default_nettype wire

@@ hdl/hudf_queue.sv @@
// ----------------------------------------------------------------------------
// hudf_queue
// Short queue of tagged bytes between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hci_uart_packet_deframer_unit_macros.svh"

module hudf_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  hudf_pkg::t_entry        i_entry,
    input  wire                     i_pop,
    output hudf_pkg::t_entry        o_entry,
    output hudf_pkg::t_queue_status o_status
);
    import hudf_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        logic [QUEUE_AW-1:0] r;
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + QUEUE_AW'(1);
        end
        return r;
    endfunction

    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_entry        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `HUDF_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > QUEUE_CW'(QUEUE_DEPTH), "queue count over depth")
    `HUDF_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_status.full, "push into full queue")
    `HUDF_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_status.empty, "pop from empty queue")

endmodule

`default_nettype wire

@@ hdl/hudf_back.sv @@
// ----------------------------------------------------------------------------
// hudf_back
// Output register stage: pulls tagged bytes from the queue and hands them on.
// ----------------------------------------------------------------------------
`default_nettype none

module hudf_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  hudf_pkg::t_queue_status i_q_status,
    input  hudf_pkg::t_entry        i_entry,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire                     i_ready,
    output hudf_pkg::t_entry        o_entry
);
    import hudf_pkg::*;

    logic   r_valid;
    t_entry r_entry;

    // refill whenever the held request leaves or the register is empty
    assign o_pop   = !i_q_status.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ hdl/hci_uart_packet_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer_unit
// HCI UART (H4) stream deframer with tagged byte output.
// ----------------------------------------------------------------------------
// A parser takes one received byte per cycle whenever its two-entry queue
// has room and passes every header and payload byte of command, ACL and SCO
// packets straight through, tagged with the packet kind and with first and
// last marks; type bytes and unknown bytes between packets produce no output.
// An output register drains the queue, so the block sustains one byte per
// cycle while the output is ready; each byte is registered in the queue and
// then in the output register. These absorb short stalls on either side; an
// output stall that outlasts three held bytes blocks input.
`default_nettype none

module hci_uart_packet_deframer_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_in_byte,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [1:0] o_pkt_kind,
    output logic [7:0] o_out_byte,
    output logic       o_first_byte,
    output logic       o_last_byte
);
    import hudf_pkg::*;

    t_queue_status q_status;
    t_entry        push_entry;
    t_entry        head_entry;
    t_entry        out_entry;
    logic          push;
    logic          pop;

    hudf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    hudf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    hudf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_entry    (head_entry),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_entry    (out_entry)
    );

    assign o_pkt_kind   = out_entry.pkt_kind;
    assign o_out_byte   = out_entry.out_byte;
    assign o_first_byte = out_entry.first_byte;
    assign o_last_byte  = out_entry.last_byte;

endmodule

`default_nettype wire
